// ===== design/rcpr_pkg.sv =====
package rcpr_pkg;

    // Default width of the tick counters.
    localparam int CNT_BITS_DEF = 16;

    // Width of the configuration register index on the write port.
    localparam int CFG_IDX_W = 8;
    // Width of the configuration write data, set by the widest register.
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDER    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_VALUE    = 8'd3;

    // Register reset values.
    localparam logic [7:0]  TICK_DIVIDER_RST    = 8'd5;
    localparam logic [7:0]  DISCHARGE_TICKS_RST = 8'd10;
    localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'hFFFF;
    localparam logic [7:0]  CENTRE_VALUE_RST    = 8'd127;

    // Saturation limit of a position.
    localparam logic [7:0] POS_MAX = 8'd255;

    // Sequence phases.
    localparam logic [1:0] PH_DIS_X  = 2'd0;
    localparam logic [1:0] PH_MEAS_X = 2'd1;
    localparam logic [1:0] PH_DIS_Y  = 2'd2;
    localparam logic [1:0] PH_MEAS_Y = 2'd3;

    typedef struct packed {
        logic x_level;
        logic y_level;
        logic button_first;
        logic button_second;
    } t_in_item;

    typedef struct packed {
        logic       drive_x_low;
        logic       drive_y_low;
        logic       report_valid;
        logic [7:0] x_position;
        logic [7:0] y_position;
        logic [1:0] button_bits;
    } t_out_item;

endpackage

// ===== design/rc_paddle_position_reader.sv =====
// The result item for an input tick is registered in the cycle after the tick is taken.
// Throughput: one tick item per cycle while results are taken; the phase sequencer and counters step once per item.
// A result that waits untaken holds off the input; a new item enters in the cycle the waiting
// one is taken, so items flow back to back with no gap while the output side is ready.
// Reset: synchronous, active low; configuration returns to its defaults, the sequencer starts
// at the discharge X phase with all counters and the last-report record cleared.
module rc_paddle_position_reader #(
    parameter int COUNT_BITS = rcpr_pkg::CNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rcpr_pkg::t_in_item             i_in_item,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rcpr_pkg::t_out_item            o_out_item,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rcpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Counters and the timeout register are compared at the wider of the two widths.
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers. The port never stalls a write.
    logic [7:0]  r_tick_divider;
    logic [7:0]  r_discharge_ticks;
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_centre_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_divider    <= rcpr_pkg::TICK_DIVIDER_RST;
            r_discharge_ticks <= rcpr_pkg::DISCHARGE_TICKS_RST;
            r_timeout_ticks   <= rcpr_pkg::TIMEOUT_TICKS_RST;
            r_centre_value    <= rcpr_pkg::CENTRE_VALUE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcpr_pkg::CFG_TICK_DIVIDER:    r_tick_divider    <= i_cfg_data[7:0];
                rcpr_pkg::CFG_DISCHARGE_TICKS: r_discharge_ticks <= i_cfg_data[7:0];
                rcpr_pkg::CFG_TIMEOUT_TICKS:   r_timeout_ticks   <= i_cfg_data[15:0];
                rcpr_pkg::CFG_CENTRE_VALUE:    r_centre_value    <= i_cfg_data[7:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Sequencer state. r_raw counts discharge ticks in the discharge phases and
    // charge ticks in the measure phases. The position is kept alongside the count
    // by a sub-counter that rolls over every tick_divider ticks.
    logic [1:0]            r_phase,        n_phase;
    logic [COUNT_BITS-1:0] r_raw,          n_raw;
    logic [7:0]            r_sub,          n_sub;
    logic [7:0]            r_pos,          n_pos;
    logic [COUNT_BITS-1:0] r_x_raw,        n_x_raw;
    logic [7:0]            r_x_result,     n_x_result;
    logic                  r_x_timed_out,  n_x_timed_out;
    logic [1:0]            r_buttons,      n_buttons;
    logic [COUNT_BITS:0]   r_rep_x_raw,    n_rep_x_raw;
    logic [COUNT_BITS:0]   r_rep_y_raw,    n_rep_y_raw;
    logic [1:0]            r_rep_buttons,  n_rep_buttons;

    // Output register.
    logic                  r_out_valid;
    rcpr_pkg::t_out_item   r_out_item,     n_out_item;

    logic                  in_fire;

    // An item is taken whenever the output register is empty or being emptied.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Shared helpers for one tick.
    logic [7:0]            div_eff;
    logic [7:0]            dis_eff;
    logic [COUNT_BITS-1:0] raw_inc;
    logic [7:0]            sub_inc;
    logic                  at_limit;
    logic                  meas_level;
    logic                  meas_done;
    logic                  meas_timed;
    logic                  dis_done;
    logic [7:0]            meas_result;
    logic [COUNT_BITS:0]   xr_mark;
    logic [COUNT_BITS:0]   yr_mark;
    logic                  changed;

    always_comb begin
        // A zero divider or a zero discharge length acts as one.
        div_eff    = (r_tick_divider == 8'd0) ? 8'd1 : r_tick_divider;
        dis_eff    = (r_discharge_ticks == 8'd0) ? 8'd1 : r_discharge_ticks;
        raw_inc    = r_raw + 1'b1;
        sub_inc    = r_sub + 8'd1;
        dis_done   = (raw_inc >= COUNT_BITS'(dis_eff));
        at_limit   = (CMP_W'(r_raw) >= CMP_W'(r_timeout_ticks)) || (r_raw == COUNT_MAX);
        meas_level = (r_phase == rcpr_pkg::PH_MEAS_Y) ? i_in_item.y_level
                                                      : i_in_item.x_level;
        // The pin level is checked before the tick is counted.
        meas_done  = meas_level || at_limit;
        meas_timed = !meas_level;
        meas_result = meas_timed ? r_centre_value : r_pos;
        xr_mark    = {r_x_timed_out, r_x_raw};
        yr_mark    = {meas_timed, r_raw};
        changed    = (xr_mark != r_rep_x_raw) || (yr_mark != r_rep_y_raw)
                  || (r_buttons != r_rep_buttons);

        n_phase       = r_phase;
        n_raw         = r_raw;
        n_sub         = r_sub;
        n_pos         = r_pos;
        n_x_raw       = r_x_raw;
        n_x_result    = r_x_result;
        n_x_timed_out = r_x_timed_out;
        n_buttons     = r_buttons;
        n_rep_x_raw   = r_rep_x_raw;
        n_rep_y_raw   = r_rep_y_raw;
        n_rep_buttons = r_rep_buttons;
        n_out_item    = '0;

        unique case (r_phase) inside
            rcpr_pkg::PH_DIS_X: begin
                // Buttons are sampled on the first discharge X tick.
                if (r_raw == '0) begin
                    n_buttons = {i_in_item.button_second, i_in_item.button_first};
                end
                n_out_item.drive_x_low = 1'b1;
                n_raw = raw_inc;
                if (dis_done) begin
                    n_phase = rcpr_pkg::PH_MEAS_X;
                    n_raw   = '0;
                    n_sub   = '0;
                    n_pos   = '0;
                end
            end
            rcpr_pkg::PH_DIS_Y: begin
                n_out_item.drive_y_low = 1'b1;
                n_raw = raw_inc;
                if (dis_done) begin
                    n_phase = rcpr_pkg::PH_MEAS_Y;
                    n_raw   = '0;
                    n_sub   = '0;
                    n_pos   = '0;
                end
            end
            rcpr_pkg::PH_MEAS_X, rcpr_pkg::PH_MEAS_Y: begin
                if (meas_done) begin
                    n_raw = '0;
                    if (r_phase == rcpr_pkg::PH_MEAS_X) begin
                        n_x_raw       = r_raw;
                        n_x_timed_out = meas_timed;
                        n_x_result    = meas_result;
                        n_phase       = rcpr_pkg::PH_DIS_Y;
                    end else begin
                        // A report goes out only when something moved since the last one.
                        if (changed) begin
                            n_out_item.report_valid = 1'b1;
                            n_out_item.x_position   = r_x_result;
                            n_out_item.y_position   = meas_result;
                            n_out_item.button_bits  = r_buttons;
                            n_rep_x_raw   = xr_mark;
                            n_rep_y_raw   = yr_mark;
                            n_rep_buttons = r_buttons;
                        end
                        n_phase = rcpr_pkg::PH_DIS_X;
                    end
                end else begin
                    n_raw = raw_inc;
                    n_sub = sub_inc;
                    if (sub_inc >= div_eff) begin
                        n_sub = '0;
                        if (r_pos != rcpr_pkg::POS_MAX) begin
                            n_pos = r_pos + 8'd1;
                        end
                    end
                end
            end
            default: begin
                n_phase = rcpr_pkg::PH_DIS_X;
                n_raw   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rcpr_pkg::PH_DIS_X;
            r_raw         <= '0;
            r_sub         <= '0;
            r_pos         <= '0;
            r_x_raw       <= '0;
            r_x_result    <= '0;
            r_x_timed_out <= 1'b0;
            r_buttons     <= '0;
            r_rep_x_raw   <= '0;
            r_rep_y_raw   <= '0;
            r_rep_buttons <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase       <= n_phase;
                r_raw         <= n_raw;
                r_sub         <= n_sub;
                r_pos         <= n_pos;
                r_x_raw       <= n_x_raw;
                r_x_result    <= n_x_result;
                r_x_timed_out <= n_x_timed_out;
                r_buttons     <= n_buttons;
                r_rep_x_raw   <= n_rep_x_raw;
                r_rep_y_raw   <= n_rep_y_raw;
                r_rep_buttons <= n_rep_buttons;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // The result payload carries no reset; it is loaded with every accepted item.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The bench runs the block at its default counter width.
    localparam int CNT_W = rcpr_pkg::CNT_BITS_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // An index past the last register. A write to it must change nothing.
    localparam logic [rcpr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd4;

    // This limit leaves a wide margin over the slowest correct run.
    localparam int RUN_LIMIT = 400000;

    // Settle time after the last expected item before the block is treated
    // as idle. The block registers its result in the cycle after it takes a tick.
    localparam int SETTLE_CYCLES = 4;

    // Result items that are easy to read straight off the sequence.
    localparam rcpr_pkg::t_out_item NO_OUT  = '0;
    localparam rcpr_pkg::t_out_item DRIVE_X = '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 2'd0};
    localparam rcpr_pkg::t_out_item DRIVE_Y = '{1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 2'd0};

    // One row of the directed script. A row is either a register write or
    // a tick. A tick row that has typed set carries its own expected result.
    // Every other tick row is checked against the model of the block.
    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [rcpr_pkg::CFG_IDX_W-1:0]    reg_idx;
        logic [15:0]                       reg_val;
        rcpr_pkg::t_in_item                tick;
        logic                              typed;
        rcpr_pkg::t_out_item               want;
    } t_script_row;

    // One soak phase: the register settings, the idle mix and the number of ticks.
    typedef struct packed {
        logic [7:0]  tick_div;
        logic [7:0]  hold_ticks;
        logic [15:0] limit_ticks;
        logic [7:0]  centre;
        logic [7:0]  send_pct;
        logic [7:0]  recv_pct;
        logic [15:0] count;
    } t_soak_phase;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    rcpr_pkg::t_in_item              in_item   = '0;
    logic                            out_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [rcpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rcpr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    rcpr_pkg::t_out_item o_out_item;
    logic                o_cfg_ready;

    int send_idle_pct  = 31;
    int recv_idle_pct  = 87;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Expected result items, oldest first. Each accepted tick adds exactly one.
    rcpr_pkg::t_out_item pending_readings[$];

    t_script_row script [32];
    t_soak_phase soak_plan [6];

    // Shadow of the block: its registers and its sequencer state.
    logic [7:0]       div_reg   = rcpr_pkg::TICK_DIVIDER_RST;
    logic [7:0]       dis_reg   = rcpr_pkg::DISCHARGE_TICKS_RST;
    logic [15:0]      tmo_reg   = rcpr_pkg::TIMEOUT_TICKS_RST;
    logic [7:0]       ctr_reg   = rcpr_pkg::CENTRE_VALUE_RST;
    logic [1:0]       seq_phase = rcpr_pkg::PH_DIS_X;
    logic [CNT_W-1:0] tick_cnt  = '0;
    logic [7:0]       sub_cnt   = '0;
    logic [7:0]       pos_cnt   = '0;
    logic [CNT_W-1:0] x_cnt     = '0;
    logic [7:0]       x_pos     = '0;
    logic             x_tmo     = 1'b0;
    logic [1:0]       btn_latch = '0;
    logic [CNT_W:0]   last_x    = '0;
    logic [CNT_W:0]   last_y    = '0;
    logic [1:0]       last_btn  = '0;

    // Model of the paddles: the tick count at which each pin comes up
    // during the next measurement, and the buttons being held.
    logic [15:0] x_target     = 16'd3;
    logic [15:0] y_target     = 16'd5;
    logic [1:0]  held_buttons = 2'b00;

    rc_paddle_position_reader #(
        .COUNT_BITS(CNT_W)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // Clears the counters at the start of a measurement.
    function automatic void restart_count();
        tick_cnt = '0;
        sub_cnt  = '0;
        pos_cnt  = '0;
    endfunction

    // One tick of a discharge phase. The result is true when the capacitor
    // has been held low long enough. A zero setting acts as one tick.
    function automatic logic discharge_done();
        tick_cnt = tick_cnt + 1'b1;
        return 32'(tick_cnt) >= ((dis_reg == 8'd0) ? 32'd1 : 32'(dis_reg));
    endfunction

    // One tick of a measure phase. The result is true when the measurement
    // ends on this tick. The pin level is looked at before the tick is
    // counted, so a pin that is already high gives a count of zero. The
    // position steps once every div_reg ticks and stops at the maximum.
    function automatic logic measure_step(input logic level, output logic timed);
        logic [7:0] step;
        step  = (div_reg == 8'd0) ? 8'd1 : div_reg;
        timed = 1'b0;
        if (level) begin
            return 1'b1;
        end
        if (32'(tick_cnt) >= 32'(tmo_reg) || tick_cnt == CNT_MAX) begin
            timed = 1'b1;
            return 1'b1;
        end
        tick_cnt = tick_cnt + 1'b1;
        sub_cnt  = sub_cnt + 8'd1;
        if (sub_cnt >= step) begin
            sub_cnt = '0;
            if (pos_cnt != rcpr_pkg::POS_MAX) begin
                pos_cnt = pos_cnt + 8'd1;
            end
        end
        return 1'b0;
    endfunction

    // Steps the shadow sequencer by one tick and returns the result item
    // that the block should give for it. A report is given at the end of a
    // measure Y phase, and only when the raw counts, the timeout marks or the
    // buttons differ from the last report.
    function automatic rcpr_pkg::t_out_item reader_step(input rcpr_pkg::t_in_item it);
        rcpr_pkg::t_out_item r;
        logic                timed;
        logic [CNT_W:0]      x_mark;
        logic [CNT_W:0]      y_mark;
        logic [7:0]          y_pos;
        r     = '0;
        timed = 1'b0;
        case (seq_phase)
            rcpr_pkg::PH_DIS_X: begin
                if (tick_cnt == '0) begin
                    btn_latch = {it.button_second, it.button_first};
                end
                r.drive_x_low = 1'b1;
                if (discharge_done()) begin
                    seq_phase = rcpr_pkg::PH_MEAS_X;
                    restart_count();
                end
            end
            rcpr_pkg::PH_MEAS_X: begin
                if (measure_step(it.x_level, timed)) begin
                    x_cnt     = tick_cnt;
                    x_tmo     = timed;
                    x_pos     = timed ? ctr_reg : pos_cnt;
                    seq_phase = rcpr_pkg::PH_DIS_Y;
                    tick_cnt  = '0;
                end
            end
            rcpr_pkg::PH_DIS_Y: begin
                r.drive_y_low = 1'b1;
                if (discharge_done()) begin
                    seq_phase = rcpr_pkg::PH_MEAS_Y;
                    restart_count();
                end
            end
            rcpr_pkg::PH_MEAS_Y: begin
                if (measure_step(it.y_level, timed)) begin
                    x_mark = {x_tmo, x_cnt};
                    y_mark = {timed, tick_cnt};
                    y_pos  = timed ? ctr_reg : pos_cnt;
                    if (x_mark != last_x || y_mark != last_y || btn_latch != last_btn) begin
                        r.report_valid = 1'b1;
                        r.x_position   = x_pos;
                        r.y_position   = y_pos;
                        r.button_bits  = btn_latch;
                        last_x         = x_mark;
                        last_y         = y_mark;
                        last_btn       = btn_latch;
                    end
                    seq_phase = rcpr_pkg::PH_DIS_X;
                    tick_cnt  = '0;
                end
            end
        endcase
        return r;
    endfunction

    // Keeps the last charge time in a third of the picks, so that repeated
    // readings let the block hold back its report. Mostly it picks a short one,
    // and now and then a long one that saturates the position or runs into the timeout.
    function automatic logic [15:0] pick_target(input logic [15:0] last);
        int unsigned roll;
        roll = $urandom_range(0, 11);
        if (roll < 4) begin
            return last;
        end
        if (roll == 11) begin
            return 16'($urandom_range(240, 300));
        end
        return 16'($urandom_range(0, 12));
    endfunction

    // Builds the next tick from the paddle model, using the state that the
    // tick will meet. Most ticks behave like real paddles: a pin stays low
    // until its charge time, then stays high. About one tick in eight is
    // pure noise, which can cut a measurement short.
    function automatic rcpr_pkg::t_in_item make_tick();
        rcpr_pkg::t_in_item it;
        it = rcpr_pkg::t_in_item'(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 7) == 0) begin
            return it;
        end
        if (seq_phase == rcpr_pkg::PH_DIS_X && tick_cnt == '0) begin
            x_target = pick_target(x_target);
            y_target = pick_target(y_target);
            if ($urandom_range(0, 5) == 0) begin
                held_buttons = 2'($urandom_range(0, 3));
            end
            {it.button_second, it.button_first} = held_buttons;
        end
        if (seq_phase == rcpr_pkg::PH_MEAS_X) begin
            it.x_level = (16'(tick_cnt) >= x_target);
        end
        if (seq_phase == rcpr_pkg::PH_MEAS_Y) begin
            it.y_level = (16'(tick_cnt) >= y_target);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one tick after a random gap and waits for it to be taken. The
    // expected result is queued at the edge where the block accepts the tick.
    task automatic send_tick(input rcpr_pkg::t_in_item it, input logic typed,
                             input rcpr_pkg::t_out_item lit);
        rcpr_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!o_in_ready) begin
            @(posedge clk);
        end
        predicted = reader_step(it);
        pending_readings.push_back(typed ? lit : predicted);
    endtask

    // Writes one register once the block has nothing left in flight. The
    // 8-bit registers get random upper data bits, which the block must
    // ignore.
    task automatic write_reg(input logic [rcpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        logic [15:0] word;
        word = value;
        if (idx != rcpr_pkg::CFG_TIMEOUT_TICKS) begin
            word[15:8] = 8'($urandom_range(0, 255));
        end
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!o_cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            rcpr_pkg::CFG_TICK_DIVIDER:    div_reg = word[7:0];
            rcpr_pkg::CFG_DISCHARGE_TICKS: dis_reg = word[7:0];
            rcpr_pkg::CFG_TIMEOUT_TICKS:   tmo_reg = word;
            rcpr_pkg::CFG_CENTRE_VALUE:    ctr_reg = word[7:0];
            default: ;
        endcase
    endtask

    // Output side: stalls at random, and checks every item that is taken
    // against the oldest expectation. The checks use the values from before
    // the edge, so they are free of races with the block.
    always @(posedge clk) begin : out_side
        rcpr_pkg::t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result item with nothing expected", 0, 0);
            end else begin
                want = pending_readings.pop_front();
                if (o_out_item.drive_x_low !== want.drive_x_low) begin
                    report_mismatch("drive_x_low", o_out_item.drive_x_low, want.drive_x_low);
                end
                if (o_out_item.drive_y_low !== want.drive_y_low) begin
                    report_mismatch("drive_y_low", o_out_item.drive_y_low, want.drive_y_low);
                end
                if (o_out_item.report_valid !== want.report_valid) begin
                    report_mismatch("report_valid", o_out_item.report_valid,
                                    want.report_valid);
                end
                if (o_out_item.x_position !== want.x_position) begin
                    report_mismatch("x_position", o_out_item.x_position, want.x_position);
                end
                if (o_out_item.y_position !== want.y_position) begin
                    report_mismatch("y_position", o_out_item.y_position, want.y_position);
                end
                if (o_out_item.button_bits !== want.button_bits) begin
                    report_mismatch("button_bits", o_out_item.button_bits, want.button_bits);
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Tick bits are {x_level, y_level, button_first, button_second}.
        // The two ticks after reset run under the default settings, in the
        // middle of the first discharge X phase. The block then switches to
        // zero divider, zero discharge and zero timeout, which act as one,
        // one and "time out at once". The sequence covers a report of two
        // disconnected axes, a repeat that must stay silent, and two pins
        // that are high on the first measure tick. The last group uses the
        // widest divider and a timeout of three ticks.
        script = '{
            '{ROW_TICK, '0, 16'd0, 4'b0011, 1'b1, DRIVE_X},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, DRIVE_X},
            '{ROW_CFG, CFG_UNUSED_IDX, 16'hA5A5, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_TICK_DIVIDER, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_DISCHARGE_TICKS, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_TIMEOUT_TICKS, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_CENTRE_VALUE, 16'd255, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, DRIVE_X},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, DRIVE_Y},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1,
              rcpr_pkg::t_out_item'{1'b0, 1'b0, 1'b1, 8'd255, 8'd255, 2'b11}},
            '{ROW_TICK, '0, 16'd0, 4'b0011, 1'b1, DRIVE_X},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, DRIVE_Y},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0001, 1'b1, DRIVE_X},
            '{ROW_TICK, '0, 16'd0, 4'b1000, 1'b1, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b1, DRIVE_Y},
            '{ROW_TICK, '0, 16'd0, 4'b0100, 1'b1,
              rcpr_pkg::t_out_item'{1'b0, 1'b0, 1'b1, 8'd0, 8'd0, 2'b10}},
            '{ROW_CFG, rcpr_pkg::CFG_TICK_DIVIDER, 16'd255, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_DISCHARGE_TICKS, 16'd2, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_TIMEOUT_TICKS, 16'd3, 4'b0000, 1'b0, NO_OUT},
            '{ROW_CFG, rcpr_pkg::CFG_CENTRE_VALUE, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0011, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0000, 1'b0, NO_OUT},
            '{ROW_TICK, '0, 16'd0, 4'b0100, 1'b0, NO_OUT}
        };

        // Soak phases. The first two let the sender idle lightly and the
        // receiver heavily, the next two the other way round, and the last
        // two run with no gaps at all. The settings walk through the extremes
        // of every register. This includes the full 16-bit timeout with a
        // divider of one, which lets long charge times saturate the position.
        soak_plan = '{
            '{8'd1,   8'd1,   16'hFFFF, 8'd127, 8'd31, 8'd87, 16'd220},
            '{8'd3,   8'd3,   16'd8,    8'd0,   8'd31, 8'd87, 16'd200},
            '{8'd255, 8'd255, 16'd20,   8'd255, 8'd87, 8'd31, 16'd560},
            '{8'd2,   8'd1,   16'hFFFF, 8'd42,  8'd87, 8'd31, 16'd200},
            '{8'd0,   8'd0,   16'd1,    8'd200, 8'd0,  8'd0,  16'd180},
            '{8'd1,   8'd2,   16'd300,  8'd99,  8'd0,  8'd0,  16'd200}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                write_reg(script[k].reg_idx, script[k].reg_val);
            end else begin
                send_tick(script[k].tick, script[k].typed, script[k].want);
            end
        end

        foreach (soak_plan[p]) begin
            send_idle_pct = soak_plan[p].send_pct;
            recv_idle_pct <= soak_plan[p].recv_pct;
            write_reg(rcpr_pkg::CFG_TICK_DIVIDER, {8'd0, soak_plan[p].tick_div});
            write_reg(rcpr_pkg::CFG_DISCHARGE_TICKS, {8'd0, soak_plan[p].hold_ticks});
            write_reg(rcpr_pkg::CFG_TIMEOUT_TICKS, soak_plan[p].limit_ticks);
            write_reg(rcpr_pkg::CFG_CENTRE_VALUE, {8'd0, soak_plan[p].centre});
            repeat (soak_plan[p].count) begin
                send_tick(make_tick(), 1'b0, NO_OUT);
            end
        end

        // Drain what is still in flight, then let the clock run on with no input
        // so that a stray extra item would still be caught.
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
